FILE: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle property, held off while reset is low
`define VFDM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define VFDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/vfdm_pkg.sv
`default_nettype none
package vfdm_pkg;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [3:0]  BLANK_CODE = 4'd10;
  localparam logic [31:0] DOT_MASK   = 32'h0040_0000;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [3:0] position;
    logic [3:0] symbol;
    logic       dot;
  } item_t;

  // one request held in the input register
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [31:0] drive_word;
    logic [3:0]  digit_index;
  } result_t;

  function automatic logic [31:0] seg_mask(input logic [3:0] code);
    logic [31:0] m;
    case (code)
      4'd0:    m = 32'h003B_0200;
      4'd1:    m = 32'h0012_0000;
      4'd2:    m = 32'h002E_0200;
      4'd3:    m = 32'h0036_0200;
      4'd4:    m = 32'h0017_0000;
      4'd5:    m = 32'h0035_0200;
      4'd6:    m = 32'h003D_0200;
      4'd7:    m = 32'h0012_0200;
      4'd8:    m = 32'h003F_0200;
      4'd9:    m = 32'h0037_0200;
      4'd11:   m = 32'h0007_0200;
      4'd12:   m = 32'h0029_0200;
      4'd13:   m = 32'h007C_0200;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] grid_mask(input logic [3:0] idx);
    logic [31:0] m;
    case (idx)
      4'd0:    m = 32'h0000_0800;
      4'd1:    m = 32'h0080_0000;
      4'd2:    m = 32'h0000_1000;
      4'd3:    m = 32'h0000_0100;
      4'd4:    m = 32'h0000_2000;
      4'd5:    m = 32'h0000_0080;
      4'd6:    m = 32'h0000_0040;
      4'd7:    m = 32'h0000_0020;
      4'd8:    m = 32'h0000_0400;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/vfd_digit_scan_multiplexer.sv
// Scan controller for a multiplexed VFD of up to nine digits, double buffered. Each input
// request is either a digit write (in_tuser = 0), which stores symbol and dot for one
// position of the draw buffer and returns nothing, or a refresh tick (in_tuser = 1), which
// returns one drive word for the next grid in scan order. When the scan passes the last
// digit it wraps to grid 0 and the draw buffer is copied to the shown buffer in the same
// step, so a frame never shows a half-written display. One request is accepted every clock;
// a tick's drive word reaches the output through the input register and then the result
// register, and the only thing that slows intake is a result register left untaken on
// the output side. Symbol codes above 13 show blank, writes to positions at or above
// DIGIT_COUNT are dropped.
`default_nettype none
module vfd_digit_scan_multiplexer #(
  parameter int DIGIT_COUNT = 9
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [vfdm_pkg::IN_TDATA_W-1:0]  in_tdata,  // position[3:0] symbol[7:4] dot[8]
  input  wire logic [0:0]                       in_tuser,  // func[0]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [vfdm_pkg::OUT_TDATA_W-1:0]      out_tdata  // drive_word[31:0] digit_index[35:32]
);
  import vfdm_pkg::*;

  item_t   in_item;
  stage_t  stage;
  logic    take;
  logic    res_load;
  logic    out_free;
  result_t res;
  result_t out_res;

  assign in_item.func     = func_t'(in_tuser[0]);
  assign in_item.position = in_tdata[3:0];
  assign in_item.symbol   = in_tdata[7:4];
  assign in_item.dot      = in_tdata[8];

  vfdm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .take     (take),
    .stage    (stage)
  );

  vfdm_scan_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  vfdm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0000, out_res.digit_index, out_res.drive_word};

endmodule
`default_nettype wire

FILE: rtl/core/vfdm_in_stage.sv
`default_nettype none
module vfdm_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire vfdm_pkg::item_t in_item,
  input  wire logic            take,
  output vfdm_pkg::stage_t     stage
);
  import vfdm_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // register frees up when empty or when the core takes it this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule
`default_nettype wire

FILE: rtl/core/vfdm_scan_core.sv
`default_nettype none
module vfdm_scan_core #(
  parameter int DIGIT_COUNT = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vfdm_pkg::stage_t stage,
  input  wire logic             out_free,
  output logic                  take,
  output logic                  res_load,
  output vfdm_pkg::result_t     res
);
  import vfdm_pkg::*;

  localparam int         IdxW   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [3:0] DigitN = 4'(DIGIT_COUNT);

  logic [3:0]             draw_sym_r  [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] draw_dot_r;
  logic [3:0]             shown_sym_r [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] shown_dot_r;
  logic [3:0]             scan_r, scan_nxt;

  logic            is_tick;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic            wrap;
  logic [3:0]      cur;
  logic [IdxW-1:0] rd_idx;
  logic [3:0]      rd_sym;
  logic            rd_dot;

  assign is_tick  = (stage.item.func == FUNC_TICK);
  // writes never need the result register
  assign take     = stage.valid && (!is_tick || out_free);
  assign res_load = take && is_tick;

  assign wr_en  = take && !is_tick && (stage.item.position < DigitN);
  assign wr_idx = stage.item.position[IdxW-1:0];

  assign wrap     = (scan_r >= DigitN);
  assign cur      = wrap ? 4'd0 : scan_r;
  assign scan_nxt = cur + 4'd1;
  assign rd_idx   = cur[IdxW-1:0];

  // on a wrap the draw buffer is what gets shown this tick
  assign rd_sym = wrap ? draw_sym_r[rd_idx] : shown_sym_r[rd_idx];
  assign rd_dot = wrap ? draw_dot_r[rd_idx] : shown_dot_r[rd_idx];

  assign res.drive_word  = seg_mask(rd_sym) + grid_mask(cur) + (rd_dot ? DOT_MASK : 32'd0);
  assign res.digit_index = cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        draw_sym_r[k]  <= BLANK_CODE;
        shown_sym_r[k] <= BLANK_CODE;
      end
      draw_dot_r  <= '0;
      shown_dot_r <= '0;
      scan_r      <= 4'd0;
    end else begin
      if (wr_en) begin
        draw_sym_r[wr_idx] <= stage.item.symbol;
        draw_dot_r[wr_idx] <= stage.item.dot;
      end
      if (res_load) begin
        scan_r <= scan_nxt;
        if (wrap) begin
          for (int k = 0; k < DIGIT_COUNT; k++) begin
            shown_sym_r[k] <= draw_sym_r[k];
          end
          shown_dot_r <= draw_dot_r;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/vfdm_out_stage.sv
`default_nettype none
module vfdm_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire vfdm_pkg::result_t res,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vfdm_pkg::result_t      out_res
);
  import vfdm_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

FILE: rtl/core/vfdm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module vfdm_checker #(
  parameter int DIGIT_COUNT = 9
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  localparam logic [3:0] DigitN = 4'(DIGIT_COUNT);

  logic       tick_acc;
  logic       out_acc;
  logic [3:0] idx;
  logic [1:0] pend_r, pend_nxt;
  logic [3:0] last_r;
  logic       seen_r;

  assign tick_acc = in_tvalid && in_tready && in_tuser[0];
  assign out_acc  = out_tvalid && out_tready;
  assign idx      = out_tdata[35:32];
  // ticks accepted but not yet delivered
  assign pend_nxt = pend_r + {1'b0, tick_acc} - {1'b0, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      last_r <= 4'd0;
      seen_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (out_acc) begin
        last_r <= idx;
        seen_r <= 1'b1;
      end
    end
  end

  `VFDM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `VFDM_ASSERT(a_idx_range, clk, rst_n, out_tvalid |-> (idx < DigitN) && (out_tdata[39:36] == 4'd0), "digit index out of range")
  `VFDM_ASSERT(a_scan_order, clk, rst_n, out_acc |-> (idx == 4'd0) || (seen_r && (idx == last_r + 4'd1)), "scan order broken")
  `VFDM_ASSERT(a_tick_only, clk, rst_n, out_tvalid |-> (pend_r != 2'd0), "result without a refresh tick")

endmodule

bind vfd_digit_scan_multiplexer vfdm_checker #(.DIGIT_COUNT(DIGIT_COUNT)) u_vfdm_checker (.*);
`default_nettype wire
